[src/odcs_pkg.sv]
// Shared types, constants and helper functions for the OLED dimming color scale block.
package odcs_pkg;

  // Default backlight level width
  localparam int LEVEL_BITS_DEF = 10;

  // Configuration register widths and reset values
  localparam int           THR_W         = 7;
  localparam logic [6:0]   THR_RESET     = 7'd90;
  localparam logic         FE_RESET      = 1'b0;

  // Curve and gain constants
  localparam int           CURVE_LEN     = 66;
  localparam int           CURVE_W       = 9;
  localparam int           CURVE_IDX_W   = 7;
  localparam int           CURVE_SHIFT   = 7;    // gain = curve * 0x80
  localparam int           CURVE_MUL     = 65;   // CURVE_LEN - 1
  localparam int           MUL_SHIFT     = 6;    // x*65 = (x<<6) + x
  localparam logic [15:0]  SCALE_MIN     = 16'd2560;
  localparam logic [15:0]  SCALE_MAX     = 16'd32768;
  localparam int           GAIN_W        = 16;
  localparam int           DEPTH_W       = 4;

  // Backlight to gain curve, first entry at index 0
  localparam logic [CURVE_W-1:0] CURVE_TAB [0:CURVE_LEN-1] = '{
    9'd42,  9'd56,  9'd67,  9'd75,  9'd84,  9'd91,  9'd98,  9'd104, 9'd109, 9'd114,
    9'd119, 9'd124, 9'd128, 9'd133, 9'd136, 9'd140, 9'd143, 9'd146, 9'd150, 9'd152,
    9'd156, 9'd159, 9'd162, 9'd165, 9'd168, 9'd172, 9'd176, 9'd178, 9'd181, 9'd184,
    9'd187, 9'd189, 9'd192, 9'd194, 9'd196, 9'd199, 9'd202, 9'd204, 9'd206, 9'd209,
    9'd211, 9'd213, 9'd215, 9'd217, 9'd220, 9'd222, 9'd224, 9'd226, 9'd228, 9'd230,
    9'd233, 9'd236, 9'd237, 9'd239, 9'd241, 9'd241, 9'd243, 9'd245, 9'd246, 9'd249,
    9'd249, 9'd250, 9'd252, 9'd254, 9'd255, 9'd256
  };

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_DIM_THRESHOLD  = 1'b0,
    REG_FEATURE_ENABLE = 1'b1
  } cfg_reg_t;

  // Input kinds carried on in_tuser
  localparam logic MODE_LEVEL = 1'b0;
  localparam logic MODE_BLANK = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MAP,
    S_DONE
  } state_t;

  // Highest step d in 8..1 with gain >= 2^(7+d), else 0
  function automatic logic [DEPTH_W-1:0] depth_for_gain(input logic [GAIN_W-1:0] g);
    logic [DEPTH_W-1:0] d;
    d = '0;
    for (int k = 1; k <= 8; k++) begin
      if ({1'b0, g} >= (17'd1 << (7 + k))) begin
        d = DEPTH_W'(k);
      end
    end
    return d;
  endfunction

endpackage

[src/odcs_div.sv]
// Restoring serial divider: one quotient bit per cycle on a shared subtractor.
module odcs_div import odcs_pkg::*; #(
  parameter int NUM_W = LEVEL_BITS_DEF + 7,
  parameter int DEN_W = THR_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   trial;
  logic             fits;

  // One subtract and compare step
  assign trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

[src/oled_dim_backlight_to_color_scale_top.sv]
// Top level: backlight request handling, sequencer, curve mapping and result register.
//
// Usage:
//   Input beats on in_*: in_tuser is the kind (0 backlight level request,
//   1 panel blank event); in_tdata carries level and blank_now.
//   Every input beat yields exactly one output beat on out_*; out_tuser is
//   push_valid and out_tdata carries level_out and the color settings.
//   dim_threshold and feature_enable are written on the cfg_* port while idle.
// Sequencing:
//   A beat without a push goes from idle through the done state into the
//   output register; in_tready returns as the result is loaded there.
//   A beat with a push goes through the load state, the serial divider by
//   threshold-1, one quotient bit per cycle over LEVEL_BITS+7 quotient bits,
//   the map state (curve lookup and clamp) and the done state into the
//   output register; the next beat is taken when idle again. One beat is
//   in work at a time; in_tready is high only when the sequencer is idle.
// Reset: configuration returns to threshold 90 and feature off, scaling and
//   blank state are cleared, the output register is empty.
// Stall: a finished result waits in the output register; the next input beat
//   is taken and worked meanwhile and waits in turn until the register frees.
module oled_dim_backlight_to_color_scale_top import odcs_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  localparam int IN_DW     = ((LEVEL_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_FW    = LEVEL_BITS + GAIN_W + DEPTH_W + 2,
  localparam int OUT_DW    = ((OUT_FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port
  input  logic              cfg_we,
  input  logic [0:0]        cfg_addr,
  input  logic [THR_W-1:0]  cfg_wdata,
  // Input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // level, blank_now, zero pad
  input  logic              in_tuser,   // mode
  // Output stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // level_out, color_scale, dither_depth,
                                        // scale_on, dither_on, zero pad
  output logic              out_tuser   // push_valid
);

  localparam int NUM_W = LEVEL_BITS + 7;

  // Configuration and persistent state
  logic [THR_W-1:0] thr_r;
  logic             fe_r;
  logic             scaling_r;
  logic             blanked_r;

  // Per-item working registers
  state_t                state_r, state_nxt;
  logic [LEVEL_BITS-1:0] lvl_out_r;
  logic [LEVEL_BITS-1:0] lvl_map_r;
  logic                  push_r;
  logic                  on_r;
  logic                  dith_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [DEPTH_W-1:0]    depth_r;

  // Output register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_user_r;

  // Decoded input beat
  logic                  in_acc;
  logic                  in_mode;
  logic [LEVEL_BITS-1:0] in_lvl;
  logic                  in_blank;
  logic [LEVEL_BITS-1:0] thr_ext;
  logic                  qualify;
  logic                  do_push;

  // Sequencer outputs
  logic div_start;
  logic out_load;

  // Divider interface
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] lvl_m1;
  logic [NUM_W-1:0] quo;
  logic             div_done;

  // Curve mapping
  logic [CURVE_IDX_W-1:0] idx0;
  logic [GAIN_W-1:0]      gain_raw;
  logic [GAIN_W-1:0]      gain_clamped;

  assign in_mode  = in_tuser;
  assign in_lvl   = in_tdata[LEVEL_BITS-1:0];
  assign in_blank = in_tdata[LEVEL_BITS];
  assign thr_ext  = LEVEL_BITS'(thr_r);
  assign in_acc   = in_tvalid && in_tready;

  // Request decision
  assign qualify = fe_r && (in_lvl != '0) && (in_lvl < thr_ext) && !blanked_r;
  assign do_push = (in_mode == MODE_LEVEL) && (in_lvl != '0) && (qualify || scaling_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = do_push ? S_LOAD : S_DONE;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_MAP;
      S_MAP:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_LOAD: div_start = 1'b1;
      S_DONE: out_load  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Numerator (level-1)*65, zero for level zero
  assign lvl_m1 = NUM_W'(lvl_map_r) - NUM_W'(1);
  assign num    = (lvl_map_r == '0) ? '0 : ((lvl_m1 << MUL_SHIFT) + lvl_m1);

  odcs_div #(
    .NUM_W (NUM_W),
    .DEN_W (THR_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (thr_r - 1'b1),
    .quo   (quo),
    .done  (div_done)
  );

  // Curve index saturates to full scale; threshold of one or less also lands there
  assign idx0 = ((thr_r <= THR_W'(1)) || (quo >= NUM_W'(CURVE_MUL)))
              ? CURVE_IDX_W'(CURVE_LEN - 1) : quo[CURVE_IDX_W-1:0];
  assign gain_raw = {CURVE_TAB[idx0], CURVE_SHIFT'(0)};
  always_comb begin
    gain_clamped = gain_raw;
    if (gain_raw < SCALE_MIN) gain_clamped = SCALE_MIN;
    if (gain_raw > SCALE_MAX) gain_clamped = SCALE_MAX;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      fe_r        <= FE_RESET;
      scaling_r   <= 1'b0;
      blanked_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_DIM_THRESHOLD:  thr_r <= cfg_wdata;
          REG_FEATURE_ENABLE: fe_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_mode == MODE_BLANK) begin
          blanked_r <= in_blank;
        end else if (in_lvl != '0) begin
          if (qualify) scaling_r <= 1'b1;
          else         scaling_r <= 1'b0;
        end
      end
      if (out_load)                       out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  // Item payload captured at accept; gain and depth captured in the map state
  always_ff @(posedge clk) begin
    if (in_acc) begin
      push_r    <= do_push;
      on_r      <= qualify;
      dith_r    <= fe_r && !blanked_r;
      lvl_map_r <= qualify ? in_lvl : thr_ext;
      if (in_mode == MODE_BLANK) lvl_out_r <= '0;
      else if (qualify)          lvl_out_r <= thr_ext;
      else                       lvl_out_r <= in_lvl;
    end
    if (state_r == S_MAP) begin
      gain_r  <= gain_clamped;
      depth_r <= depth_for_gain(gain_clamped);
    end
  end

  // Output register load
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_user_r <= push_r;
      out_data_r <= OUT_DW'({
        push_r ? dith_r  : 1'b0,
        push_r ? on_r    : 1'b0,
        push_r ? depth_r : {DEPTH_W{1'b0}},
        push_r ? gain_r  : {GAIN_W{1'b0}},
        lvl_out_r
      });
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
